FILE: rtl/ball_joint_constraint_jacobian_macros.svh
// assertion macros for the ball joint constraint block
// expects clk and arst_n in the module that uses them
`ifndef BALL_JOINT_CONSTRAINT_JACOBIAN_MACROS_SVH
`define BALL_JOINT_CONSTRAINT_JACOBIAN_MACROS_SVH

// consequent checked in the same cycle
`define BJCJ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define BJCJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bjcj_pkg.sv
// shared widths, codes and controller/datapath interface types
// no dependencies
package bjcj_pkg;

	localparam int DATA_W             = 32;
	localparam int QUAT_W             = 16;
	localparam int LANES              = 3;
	localparam int CFG_IDX_W          = 3;
	localparam int QUAT_FRAC_BITS_DEF = 14;

	localparam logic CMD_BODY_A = 1'b0;
	localparam logic CMD_BODY_B = 1'b1;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ANCHOR_A_X = 3'd0,
		CFG_ANCHOR_A_Y = 3'd1,
		CFG_ANCHOR_A_Z = 3'd2,
		CFG_ANCHOR_B_X = 3'd3,
		CFG_ANCHOR_B_Y = 3'd4,
		CFG_ANCHOR_B_Z = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic load;
		logic mul_v;
		logic form_t;
		logic mul_t;
		logic mul_w;
		logic sum;
		logic rot;
		logic store_a;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic body_b;
	} dp_stat_t;

endpackage

FILE: rtl/bjcj_dp.sv
// datapath: anchor registers, three multiplier lanes, first body store, result register
// depends on bjcj_pkg
module bjcj_dp import bjcj_pkg::*; #(
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dp_cmd_t                          cmd,
	output dp_stat_t                         stat,
	input  logic                             cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]             cfg_index,
	input  logic [DATA_W-1:0]                cfg_data,
	input  logic                             command,
	input  logic [LANES-1:0][DATA_W-1:0]     pos,
	input  logic [QUAT_W-1:0]                quat_w,
	input  logic [LANES-1:0][QUAT_W-1:0]     quat_v,
	output logic [LANES-1:0][DATA_W-1:0]     violation,
	output logic [LANES-1:0][DATA_W-1:0]     world_a,
	output logic [LANES-1:0][DATA_W-1:0]     world_b
);

	localparam int T_W  = QUAT_W + DATA_W + 2 - QUAT_FRAC_BITS;
	localparam int B_W  = (T_W > DATA_W) ? T_W : DATA_W;
	localparam int P_W  = QUAT_W + B_W;
	localparam int TS_W = P_W + 2;
	localparam int U_W  = T_W + QUAT_W + 1;
	localparam int S_W  = T_W + QUAT_W + 3;
	localparam int SH_W = S_W - QUAT_FRAC_BITS;
	localparam int R_W  = ((SH_W > DATA_W) ? SH_W : DATA_W) + 1;
	localparam int G_W  = DATA_W + 2;

	localparam logic signed [TS_W-1:0] T_HALF = TS_W'(1) <<< (QUAT_FRAC_BITS - 1);
	localparam logic signed [S_W-1:0]  S_HALF = S_W'(1) <<< (QUAT_FRAC_BITS - 1);

	logic                       cmd_q;
	logic signed [QUAT_W-1:0]   qw_q;
	logic signed [QUAT_W-1:0]   qv_q      [LANES];
	logic signed [DATA_W-1:0]   pos_q     [LANES];
	logic signed [DATA_W-1:0]   anchor_a_q[LANES];
	logic signed [DATA_W-1:0]   anchor_b_q[LANES];
	logic signed [DATA_W-1:0]   ra_q      [LANES];
	logic signed [DATA_W-1:0]   pa_q      [LANES];
	logic signed [P_W-1:0]      p_q       [LANES];
	logic signed [P_W-1:0]      n_q       [LANES];
	logic signed [T_W-1:0]      t_q       [LANES];
	logic signed [U_W-1:0]      u_q       [LANES];
	logic signed [S_W-1:0]      s_q       [LANES];
	logic signed [DATA_W-1:0]   r_q       [LANES];
	logic signed [DATA_W-1:0]   viol_q    [LANES];
	logic signed [DATA_W-1:0]   wa_q      [LANES];
	logic signed [DATA_W-1:0]   wb_q      [LANES];

	logic signed [DATA_W-1:0]   v_sel     [LANES];
	logic signed [P_W-1:0]      prod1     [LANES];
	logic signed [P_W-1:0]      prod2     [LANES];
	logic signed [T_W-1:0]      t_next    [LANES];
	logic signed [U_W-1:0]      u_next    [LANES];
	logic signed [S_W-1:0]      s_next    [LANES];
	logic signed [DATA_W-1:0]   r_next    [LANES];
	logic signed [DATA_W-1:0]   g_next    [LANES];

	assign stat.body_b = (cmd_q == CMD_BODY_B);

	// configuration and first body store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LANES; l++) begin
				anchor_a_q[l] <= '0;
				anchor_b_q[l] <= '0;
				ra_q[l]       <= '0;
				pa_q[l]       <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ANCHOR_A_X: anchor_a_q[0] <= cfg_data;
					CFG_ANCHOR_A_Y: anchor_a_q[1] <= cfg_data;
					CFG_ANCHOR_A_Z: anchor_a_q[2] <= cfg_data;
					CFG_ANCHOR_B_X: anchor_b_q[0] <= cfg_data;
					CFG_ANCHOR_B_Y: anchor_b_q[1] <= cfg_data;
					CFG_ANCHOR_B_Z: anchor_b_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.store_a) begin
				for (int l = 0; l < LANES; l++) begin
					ra_q[l] <= r_q[l];
					pa_q[l] <= pos_q[l];
				end
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			qw_q  <= quat_w;
			for (int l = 0; l < LANES; l++) begin
				qv_q[l]  <= quat_v[l];
				pos_q[l] <= pos[l];
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < LANES; i++) begin : g_lane
			localparam int J = (i + 1) % LANES;
			localparam int K = (i + 2) % LANES;

			logic signed [QUAT_W-1:0] mul1_a;
			logic signed [B_W-1:0]    mul1_b;
			logic signed [QUAT_W-1:0] mul2_a;
			logic signed [B_W-1:0]    mul2_b;
			logic signed [TS_W-1:0]   t_sum;
			logic signed [TS_W-1:0]   t_shift;
			logic signed [P_W:0]      u_diff;
			logic signed [S_W-1:0]    s_shift;
			logic signed [R_W-1:0]    r_wide;
			logic signed [G_W-1:0]    g_wide;

			assign v_sel[i] = (cmd_q == CMD_BODY_B) ? anchor_b_q[i] : anchor_a_q[i];

			// operand select: anchor cross product, rotated cross product, scalar term
			always_comb begin
				mul1_a = qv_q[J];
				mul1_b = B_W'(v_sel[K]);
				mul2_a = qv_q[K];
				mul2_b = B_W'(v_sel[J]);
				if (cmd.mul_t) begin
					mul1_b = B_W'(t_q[K]);
					mul2_b = B_W'(t_q[J]);
				end
				if (cmd.mul_w) begin
					mul1_a = qw_q;
					mul1_b = B_W'(t_q[i]);
				end
			end

			assign prod1[i] = P_W'(mul1_a) * P_W'(mul1_b);
			assign prod2[i] = P_W'(mul2_a) * P_W'(mul2_b);

			// round half up to the anchor scale
			assign t_sum     = TS_W'(p_q[i]) - TS_W'(n_q[i]) + T_HALF;
			assign t_shift   = t_sum >>> QUAT_FRAC_BITS;
			assign t_next[i] = t_shift[T_W-1:0];

			assign u_diff    = (P_W+1)'(p_q[i]) - (P_W+1)'(n_q[i]);
			assign u_next[i] = u_diff[U_W-1:0];

			assign s_next[i] = ((S_W'(u_q[i]) + S_W'(p_q[i])) <<< 1) + S_HALF;

			assign s_shift = s_q[i] >>> QUAT_FRAC_BITS;
			assign r_wide  = R_W'(v_sel[i]) + R_W'($signed(s_shift[SH_W-1:0]));

			always_comb begin
				if (r_wide[R_W-1:DATA_W-1] != {(R_W-DATA_W+1){r_wide[R_W-1]}}) begin
					r_next[i] = r_wide[R_W-1] ? SAT_MIN : SAT_MAX;
				end else begin
					r_next[i] = r_wide[DATA_W-1:0];
				end
			end

			assign g_wide = G_W'(pos_q[i]) + G_W'(r_q[i]) - G_W'(pa_q[i]) - G_W'(ra_q[i]);

			always_comb begin
				if (g_wide[G_W-1:DATA_W-1] != {(G_W-DATA_W+1){g_wide[G_W-1]}}) begin
					g_next[i] = g_wide[G_W-1] ? SAT_MIN : SAT_MAX;
				end else begin
					g_next[i] = g_wide[DATA_W-1:0];
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.mul_v || cmd.mul_t || cmd.mul_w) begin
					p_q[i] <= prod1[i];
				end
				if (cmd.mul_v || cmd.mul_t) begin
					n_q[i] <= prod2[i];
				end
				if (cmd.form_t) begin
					t_q[i] <= t_next[i];
				end
				if (cmd.mul_w) begin
					u_q[i] <= u_next[i];
				end
				if (cmd.sum) begin
					s_q[i] <= s_next[i];
				end
				if (cmd.rot) begin
					r_q[i] <= r_next[i];
				end
				if (cmd.load_out) begin
					viol_q[i] <= g_next[i];
					wa_q[i]   <= ra_q[i];
					wb_q[i]   <= r_q[i];
				end
			end

			assign violation[i] = viol_q[i];
			assign world_a[i]   = wa_q[i];
			assign world_b[i]   = wb_q[i];
		end
	endgenerate

endmodule

FILE: rtl/bjcj_ctrl.sv
// controller: sequences the datapath steps and owns the input and result handshakes
// depends on bjcj_pkg and the assertion macro header
`include "ball_joint_constraint_jacobian_macros.svh"

module bjcj_ctrl import bjcj_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_stall,
	output logic     result_valid,
	input  logic     result_stall,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_MUL_V  = 8'b0000_0010,
		ST_FORM_T = 8'b0000_0100,
		ST_MUL_T  = 8'b0000_1000,
		ST_MUL_W  = 8'b0001_0000,
		ST_SUM    = 8'b0010_0000,
		ST_ROT    = 8'b0100_0000,
		ST_FIN    = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;
	logic   out_free;

	assign out_free     = !result_valid_q || !result_stall;
	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL_V;
				end
			end
			ST_MUL_V: begin
				cmd.mul_v = 1'b1;
				state_d   = ST_FORM_T;
			end
			ST_FORM_T: begin
				cmd.form_t = 1'b1;
				state_d    = ST_MUL_T;
			end
			ST_MUL_T: begin
				cmd.mul_t = 1'b1;
				state_d   = ST_MUL_W;
			end
			ST_MUL_W: begin
				cmd.mul_w = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!stat.body_b) begin
					cmd.store_a = 1'b1;
					state_d     = ST_IDLE;
				end else if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	`BJCJ_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "no stall after transfer")
	`BJCJ_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, !result_valid || !result_stall, "result overwritten")
	`BJCJ_ASSERT_NOW(a_store_only_first, cmd.store_a, !cmd.load_out && !stat.body_b, "bad first body store")
	`BJCJ_ASSERT_NOW(a_result_from_fin, $rose(result_valid), $past(state_q == ST_FIN), "result without item")

endmodule

FILE: rtl/ball_joint_constraint_jacobian.sv
// channel   | handshake                 | payload
// item      | item_valid / item_stall   | command, pos_x/y/z, quat_w/x/y/z
// result    | result_valid / result_stall | violation_x/y/z, world_anchor_a/b_x/y/z
// config    | cfg_wr_en                 | cfg_index, cfg_data
//
// one item at a time, stalled from the transfer through steps mul_v to fin, since the three
// multiplier lanes (two multipliers each) serve both cross products and the scalar term
// a body B result is registered on leaving fin and sits in the output register until taken
// a second body item waits in its last step while an earlier result is stalled
// reset clears the controller, the anchor registers and the stored first body
//
// top level of the ball joint constraint block, depends on bjcj_pkg, bjcj_ctrl, bjcj_dp
module ball_joint_constraint_jacobian import bjcj_pkg::*; #(
	parameter int QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data,
	input  logic                     item_valid,
	output logic                     item_stall,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] pos_x,
	input  logic signed [DATA_W-1:0] pos_y,
	input  logic signed [DATA_W-1:0] pos_z,
	input  logic signed [QUAT_W-1:0] quat_w,
	input  logic signed [QUAT_W-1:0] quat_x,
	input  logic signed [QUAT_W-1:0] quat_y,
	input  logic signed [QUAT_W-1:0] quat_z,
	output logic                     result_valid,
	input  logic                     result_stall,
	output logic signed [DATA_W-1:0] violation_x,
	output logic signed [DATA_W-1:0] violation_y,
	output logic signed [DATA_W-1:0] violation_z,
	output logic signed [DATA_W-1:0] world_anchor_a_x,
	output logic signed [DATA_W-1:0] world_anchor_a_y,
	output logic signed [DATA_W-1:0] world_anchor_a_z,
	output logic signed [DATA_W-1:0] world_anchor_b_x,
	output logic signed [DATA_W-1:0] world_anchor_b_y,
	output logic signed [DATA_W-1:0] world_anchor_b_z
);

	dp_cmd_t                      cmd;
	dp_stat_t                     stat;
	logic [LANES-1:0][DATA_W-1:0] pos;
	logic [LANES-1:0][QUAT_W-1:0] quat_v;
	logic [LANES-1:0][DATA_W-1:0] violation;
	logic [LANES-1:0][DATA_W-1:0] world_a;
	logic [LANES-1:0][DATA_W-1:0] world_b;

	assign pos[0]    = pos_x;
	assign pos[1]    = pos_y;
	assign pos[2]    = pos_z;
	assign quat_v[0] = quat_x;
	assign quat_v[1] = quat_y;
	assign quat_v[2] = quat_z;

	assign violation_x      = violation[0];
	assign violation_y      = violation[1];
	assign violation_z      = violation[2];
	assign world_anchor_a_x = world_a[0];
	assign world_anchor_a_y = world_a[1];
	assign world_anchor_a_z = world_a[2];
	assign world_anchor_b_x = world_b[0];
	assign world_anchor_b_y = world_b[1];
	assign world_anchor_b_z = world_b[2];

	bjcj_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

	bjcj_dp #(
		.QUAT_FRAC_BITS (QUAT_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.command   (command),
		.pos       (pos),
		.quat_w    (quat_w),
		.quat_v    (quat_v),
		.violation (violation),
		.world_a   (world_a),
		.world_b   (world_b)
	);

endmodule
